FILE: rtl/sra_pkg.sv
// Shared status codes for the shelf rectangle allocator.
`timescale 1ns / 1ps

package sra_pkg;

  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

endpackage

FILE: rtl/shelf_rect_allocator_top.sv
// First-fit shelf allocator that places rectangles into square atlas pages.
// An oversized request goes straight to its result; any other request walks the open
//   pages and checks one shelf per cycle through the shelf memory, then tries a new
//   shelf on that page or opens a new page. One request is in work at a time.
// Reset (synchronous, rst_n low) empties all pages; shelf memory is not cleared.
`timescale 1ns / 1ps

module shelf_rect_allocator_top
  import sra_pkg::*;
#(
  parameter int PAGE_SIZE   = 1024,
  parameter int PAD         = 1,
  parameter int MAX_PAGES   = 4,
  parameter int MAX_SHELVES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rect_width[10:0], rect_height[21:11], zero[23:22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], page_index[3:2], pos_x[13:4], pos_y[23:14]
);

  localparam int CW    = $clog2(PAGE_SIZE + 1);
  localparam int DW    = $clog2(2047 + PAD + 1);
  localparam int XW    = ((DW > CW) ? DW : CW) + 1;
  localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW   = $clog2(MAX_PAGES + 1);
  localparam int SW    = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int SCW   = $clog2(MAX_SHELVES + 1);
  localparam int EW    = 3 * CW;
  localparam int DEPTH = MAX_PAGES << SW;
  localparam int AW    = PW + SW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAGE = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [PCW-1:0]   page_r, page_nxt;
  logic [SCW-1:0]   shelf_r, shelf_nxt;
  logic [PCW-1:0]   pages_open_r, pages_open_nxt;
  logic [SCW-1:0]   shelves_r [MAX_PAGES];
  logic [CW-1:0]    pw_r, pw_nxt, ph_r, ph_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [PCW-1:0]   res_page_r, res_page_nxt;
  logic [CW-1:0]    res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  // Shelf memory: {fill_x, top_y, height} per entry, address {page, shelf}.
  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_wdata;

  logic             shelf_we;
  logic [PW-1:0]    shelf_widx;
  logic [SCW-1:0]   shelf_wval;

  logic [XW-1:0]    in_pw, in_ph;
  logic [SCW-1:0]   cur_n;
  logic [CW-1:0]    rd_fill, rd_top, rd_h;
  logic [XW-1:0]    next_y;
  logic [SW-1:0]    rd_idx;

  assign in_pw   = XW'(in_tdata[10:0]) + XW'(PAD);
  assign in_ph   = XW'(in_tdata[21:11]) + XW'(PAD);
  assign cur_n   = shelves_r[page_r[PW-1:0]];
  assign rd_fill = rdata_r[3*CW-1:2*CW];
  assign rd_top  = rdata_r[2*CW-1:CW];
  assign rd_h    = rdata_r[CW-1:0];
  assign next_y  = XW'(rd_top) + XW'(rd_h);

  // During a scan the read runs one shelf ahead of the check.
  assign rd_idx    = (state_r == S_SCAN) ? (shelf_r[SW-1:0] + SW'(1)) : '0;
  assign mem_raddr = {page_r[PW-1:0], rd_idx};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    shelf_nxt      = shelf_r;
    pages_open_nxt = pages_open_r;
    pw_nxt         = pw_r;
    ph_nxt         = ph_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = {page_r[PW-1:0], SW'(0)};
    mem_wdata      = {pw_r, CW'(0), ph_r};
    shelf_we       = 1'b0;
    shelf_widx     = page_r[PW-1:0];
    shelf_wval     = SCW'(1);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_page_nxt = '0;
          res_x_nxt    = '0;
          res_y_nxt    = '0;
          if (in_pw > XW'(PAGE_SIZE) || in_ph > XW'(PAGE_SIZE)) begin
            res_status_nxt = ST_OVERSIZE;
            state_nxt      = S_DONE;
          end else begin
            pw_nxt    = CW'(in_pw);
            ph_nxt    = CW'(in_ph);
            page_nxt  = '0;
            state_nxt = S_PAGE;
          end
        end
      end

      S_PAGE: begin
        if (page_r < pages_open_r) begin
          if (cur_n == '0) begin
            mem_we         = 1'b1;
            shelf_we       = 1'b1;
            res_status_nxt = ST_PLACED;
            res_page_nxt   = page_r;
            state_nxt      = S_DONE;
          end else begin
            shelf_nxt = '0;
            state_nxt = S_SCAN;
          end
        end else if (pages_open_r >= PCW'(MAX_PAGES)) begin
          res_status_nxt = ST_NO_ROOM;
          state_nxt      = S_DONE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = {pages_open_r[PW-1:0], SW'(0)};
          shelf_we       = 1'b1;
          shelf_widx     = pages_open_r[PW-1:0];
          pages_open_nxt = pages_open_r + PCW'(1);
          res_status_nxt = ST_PLACED;
          res_page_nxt   = pages_open_r;
          state_nxt      = S_DONE;
        end
      end

      S_SCAN: begin
        if (XW'(rd_fill) + XW'(pw_r) <= XW'(PAGE_SIZE) && ph_r <= rd_h) begin
          mem_we         = 1'b1;
          mem_waddr      = {page_r[PW-1:0], shelf_r[SW-1:0]};
          mem_wdata      = {CW'(rd_fill + pw_r), rd_top, rd_h};
          res_status_nxt = ST_PLACED;
          res_page_nxt   = page_r;
          res_x_nxt      = rd_fill;
          res_y_nxt      = rd_top;
          state_nxt      = S_DONE;
        end else if (shelf_r == cur_n - SCW'(1)) begin
          // Last shelf checked: its bottom edge is where a new shelf would go.
          if (cur_n < SCW'(MAX_SHELVES) && next_y + XW'(ph_r) <= XW'(PAGE_SIZE)) begin
            mem_we         = 1'b1;
            mem_waddr      = {page_r[PW-1:0], cur_n[SW-1:0]};
            mem_wdata      = {pw_r, CW'(next_y), ph_r};
            shelf_we       = 1'b1;
            shelf_wval     = cur_n + SCW'(1);
            res_status_nxt = ST_PLACED;
            res_page_nxt   = page_r;
            res_y_nxt      = CW'(next_y);
            state_nxt      = S_DONE;
          end else begin
            page_nxt  = page_r + PCW'(1);
            state_nxt = S_PAGE;
          end
        end else begin
          shelf_nxt = shelf_r + SCW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {10'(res_y_r), 10'(res_x_r), 2'(res_page_r), res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A write always ends a request, and the next request reads only after S_DONE and
  // S_IDLE, so read and write never collide on one entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pages_open_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        shelves_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      pages_open_r <= pages_open_nxt;
      out_valid_r  <= out_valid_nxt;
      if (shelf_we) begin
        shelves_r[shelf_widx] <= shelf_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    shelf_r      <= shelf_nxt;
    pw_r         <= pw_nxt;
    ph_r         <= ph_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

FILE: rtl/sra_checker.sv
// Port-level checks for the shelf rectangle allocator, bound to the top level.
`timescale 1ns / 1ps

module sra_checker
  import sra_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] == ST_PLACED || out_tdata[1:0] == ST_NO_ROOM
                   || out_tdata[1:0] == ST_OVERSIZE)
    else $error("undefined status code");

  // A failed request carries no position.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_PLACED |-> out_tdata[23:2] == 22'd0)
    else $error("failed request with nonzero page or position");

endmodule

bind shelf_rect_allocator_top sra_checker u_sra_checker (.*);

FILE: bench/tb_top.sv
// Self-checking testbench for the shelf rectangle allocator, with its own placement predictor.
`timescale 1ns / 1ps

module tb_top;
  import sra_pkg::*;

  localparam int PAGE_PX    = 1024;
  localparam int PAD_PX     = 1;
  localparam int PAGE_COUNT = 4;
  localparam int SHELF_CAP  = 64;

  localparam int RANDOM_RECTS = 1000;
  localparam int HOLD_AFTER   = 300;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = PAGE_COUNT * (SHELF_CAP + 1) + 40;
  localparam int IDLE_LIMIT   = 6000;

  typedef struct packed {
    logic [9:0] pos_y;
    logic [9:0] pos_x;
    logic [1:0] page;
    logic [1:0] status;
  } alloc_result_t;

  typedef struct packed {
    logic [10:0] w;
    logic [10:0] h;
    logic        fixed;
    logic [1:0]  st;
    logic [1:0]  pg;
    logic [9:0]  x;
    logic [9:0]  y;
  } stim_row_t;

  localparam int N_DIRECTED = 15;
  // Rows with fixed set carry the result typed in; the others go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{11'd1023, 11'd0,    1'b1, ST_PLACED,   2'd0, 10'd0, 10'd0},
    '{11'd1024, 11'd0,    1'b1, ST_OVERSIZE, 2'd0, 10'd0, 10'd0},
    '{11'd0,    11'd1024, 1'b1, ST_OVERSIZE, 2'd0, 10'd0, 10'd0},
    '{11'd2047, 11'd2047, 1'b1, ST_OVERSIZE, 2'd0, 10'd0, 10'd0},
    '{11'd1025, 11'd1,    1'b1, ST_OVERSIZE, 2'd0, 10'd0, 10'd0},
    // A zero-sized rectangle still takes one padded pixel, on a new shelf below the first.
    '{11'd0,    11'd0,    1'b1, ST_PLACED,   2'd0, 10'd0, 10'd1},
    '{11'd0,    11'd0,    1'b1, ST_PLACED,   2'd0, 10'd1, 10'd1},
    '{11'd10,   11'd5,    1'b0, ST_PLACED,   2'd0, 10'd0, 10'd0},
    '{11'd3,    11'd2,    1'b0, ST_PLACED,   2'd0, 10'd0, 10'd0},
    // The largest rectangle needs a fresh page of its own.
    '{11'd1023, 11'd1023, 1'b1, ST_PLACED,   2'd1, 10'd0, 10'd0},
    '{11'd1023, 11'd7,    1'b0, ST_PLACED,   2'd0, 10'd0, 10'd0},
    '{11'd40,   11'd7,    1'b0, ST_PLACED,   2'd0, 10'd0, 10'd0},
    '{11'd0,    11'd12,   1'b0, ST_PLACED,   2'd0, 10'd0, 10'd0},
    '{11'd12,   11'd0,    1'b0, ST_PLACED,   2'd0, 10'd0, 10'd0},
    '{11'd1500, 11'd3,    1'b1, ST_OVERSIZE, 2'd0, 10'd0, 10'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // rect_width[10:0], rect_height[21:11], zero[23:22]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // status[1:0], page_index[3:2], pos_x[13:4], pos_y[23:14]

  // Predictor copy of the packing state.
  int fill_x  [PAGE_COUNT][SHELF_CAP];
  int top_y   [PAGE_COUNT][SHELF_CAP];
  int shelf_h [PAGE_COUNT][SHELF_CAP];
  int shelf_cnt [PAGE_COUNT];
  int open_pages;

  alloc_result_t pending_placements [$];
  int mismatch_count;
  int results_seen;
  int idle_cycles;
  bit steady_window;

  shelf_rect_allocator_top #(
    .PAGE_SIZE  (PAGE_PX),
    .PAD        (PAD_PX),
    .MAX_PAGES  (PAGE_COUNT),
    .MAX_SHELVES(SHELF_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic alloc_result_t place_rect(input int w, input int h);
    alloc_result_t r;
    int pw, ph, p, s, n, next_y;
    r = '0;
    r.status = ST_PLACED;
    pw = w + PAD_PX;
    ph = h + PAD_PX;
    if (pw > PAGE_PX || ph > PAGE_PX) begin
      r.status = ST_OVERSIZE;
      return r;
    end
    for (p = 0; p < open_pages; p++) begin
      n = shelf_cnt[p];
      for (s = 0; s < n; s++) begin
        if (fill_x[p][s] + pw <= PAGE_PX && ph <= shelf_h[p][s]) begin
          r.page  = p[1:0];
          r.pos_x = fill_x[p][s][9:0];
          r.pos_y = top_y[p][s][9:0];
          fill_x[p][s] += pw;
          return r;
        end
      end
      if (n < SHELF_CAP) begin
        next_y = (n == 0) ? 0 : top_y[p][n-1] + shelf_h[p][n-1];
        if (next_y + ph <= PAGE_PX) begin
          fill_x[p][n]  = pw;
          top_y[p][n]   = next_y;
          shelf_h[p][n] = ph;
          shelf_cnt[p]  = n + 1;
          r.page  = p[1:0];
          r.pos_y = next_y[9:0];
          return r;
        end
      end
    end
    if (open_pages >= PAGE_COUNT) begin
      r.status = ST_NO_ROOM;
      return r;
    end
    p = open_pages;
    fill_x[p][0]  = pw;
    top_y[p][0]   = 0;
    shelf_h[p][0] = ph;
    shelf_cnt[p]  = 1;
    open_pages    = p + 1;
    r.page = p[1:0];
    return r;
  endfunction

  function automatic int pick_wait();
    if (steady_window) begin
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_rect(input logic [10:0] w, input logic [10:0] h,
                           input bit fixed, input alloc_result_t fixed_res);
    int gap;
    alloc_result_t pred;
    gap = pick_wait();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, h, w};
    do @(posedge clk); while (!in_tready);
    pred = place_rect(int'(w), int'(h));
    pending_placements.insert(pending_placements.size(), fixed ? fixed_res : pred);
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  // Random rectangle shaped by how far the run has come: small ones, then wide flat
  // ones that run pages into the shelf limit, a mix, tall ones that use up every page,
  // and small ones that hunt for leftover room. About one in ten is drawn from the full range.
  task automatic draw_rect(input int idx, output logic [10:0] w, output logic [10:0] h);
    if ($urandom_range(0, 9) == 0) begin
      w = 11'($urandom_range(0, 2047));
      h = 11'($urandom_range(0, 2047));
    end else if (idx < 300) begin
      w = 11'($urandom_range(0, 63));
      h = 11'($urandom_range(0, 31));
    end else if (idx < 500) begin
      w = 11'($urandom_range(512, 1023));
      h = 11'($urandom_range(0, 7));
    end else if (idx < 650) begin
      w = 11'($urandom_range(0, 1023));
      h = 11'($urandom_range(0, 255));
    end else if (idx < 800) begin
      w = 11'($urandom_range(0, 1023));
      h = 11'($urandom_range(200, 1023));
    end else begin
      w = 11'($urandom_range(0, 127));
      h = 11'($urandom_range(0, 63));
    end
  endtask

  // Receiver: random stalls, one long hold-off, and checking of every result.
  initial begin
    int stall;
    alloc_result_t want, seen;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = pick_wait();
      if (results_seen == HOLD_AFTER) begin
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      seen = out_tdata;
      results_seen++;
      if (pending_placements.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, seen);
        mismatch_count++;
      end else begin
        want = pending_placements.pop_front();
        report_field("status", int'(want.status), int'(seen.status));
        report_field("page_index", int'(want.page), int'(seen.page));
        report_field("pos_x", int'(want.pos_x), int'(seen.pos_x));
        report_field("pos_y", int'(want.pos_y), int'(seen.pos_y));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [10:0] w, h;
    alloc_result_t typed;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_cycles = 0;
    mismatch_count = 0;
    results_seen = 0;
    steady_window = 1'b0;
    open_pages = 0;
    foreach (shelf_cnt[p]) shelf_cnt[p] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed.status = DIRECTED_ROWS[i].st;
      typed.page   = DIRECTED_ROWS[i].pg;
      typed.pos_x  = DIRECTED_ROWS[i].x;
      typed.pos_y  = DIRECTED_ROWS[i].y;
      send_rect(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].h, DIRECTED_ROWS[i].fixed, typed);
    end

    for (int i = 0; i < RANDOM_RECTS; i++) begin
      // Two stretches where neither side idles.
      steady_window = (i >= 150 && i < 230) || (i >= 700 && i < 780);
      draw_rect(i, w, h);
      send_rect(w, h, 1'b0, '0);
    end
    steady_window = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
